### hdl/bilinear_texture_sampler_unit_assert.svh
// Assertion macros used by the sampler top module
`ifndef BILINEAR_TEXTURE_SAMPLER_UNIT_ASSERT_SVH
`define BILINEAR_TEXTURE_SAMPLER_UNIT_ASSERT_SVH

// Implication checked on every edge out of reset
`define BTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked out of reset
`define BTS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hdl/bts_pkg.sv
package bts_pkg;
  localparam int MAX_TEXELS_DEF = 65536;
  localparam int MAX_DIM_DEF    = 256;
  localparam int COORD_W = 18;
  localparam int DIM_W   = 9;
  localparam int IDX_W   = 16;
  localparam int CH_W    = 8;
  localparam int OUT_W   = 16;
  localparam int FRAC_W  = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = 1'd1;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef logic [3*CH_W-1:0] texel_t;
endpackage

### hdl/bts_if.sv
interface bts_in_if import bts_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [IDX_W-1:0]          texel_index;
  logic [CH_W-1:0]           red_in;
  logic [CH_W-1:0]           green_in;
  logic [CH_W-1:0]           blue_in;
  logic signed [COORD_W-1:0] u_coord;
  logic signed [COORD_W-1:0] v_coord;
  modport source (output valid, op, texel_index, red_in, green_in, blue_in, u_coord,
                  v_coord, input ready);
  modport sink (input valid, op, texel_index, red_in, green_in, blue_in, u_coord,
                v_coord, output ready);
endinterface

interface bts_out_if import bts_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] red_out;
  logic [OUT_W-1:0] green_out;
  logic [OUT_W-1:0] blue_out;
  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink (input valid, red_out, green_out, blue_out, output ready);
endinterface

interface bts_cfg_if import bts_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hdl/bts_addr.sv
// Address stage: clamp, scale, split into texel coordinates and fractions,
// form the four neighbour indices. Two register stages.
module bts_addr import bts_pkg::*; #(
  parameter int MAX_TEXELS = MAX_TEXELS_DEF,
  parameter int MAX_DIM    = MAX_DIM_DEF,
  localparam int AW = $clog2(MAX_TEXELS)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      vld_i,
  input  logic signed [COORD_W-1:0] u_i,
  input  logic signed [COORD_W-1:0] v_i,
  input  logic [DIM_W-1:0]          wid_i,
  input  logic [DIM_W-1:0]          hgt_i,
  output logic                      vld_o,
  output logic [AW-1:0]             a00_o,
  output logic [AW-1:0]             a10_o,
  output logic [AW-1:0]             a01_o,
  output logic [AW-1:0]             a11_o,
  output logic [FRAC_W-1:0]         s_o,
  output logic [FRAC_W-1:0]         t_o
);
  localparam int CW = FRAC_W + 1;  // clamped coordinate, 0..65536
  localparam int DW = DIM_W + 2;
  localparam int PW = CW + DW;

  logic [DW-1:0] w_eff, h_eff;
  logic [CW-1:0] u_c, v_c;
  logic          vld1_r;
  logic [PW-1:0] px_r, py_r;
  logic [DW-1:0] w1_r;

  function automatic logic [DW-1:0] eff_dim(input logic [DIM_W-1:0] d);
    if (d == '0) return DW'(1);
    if ({2'b0, d} > DW'(MAX_DIM)) return DW'(MAX_DIM);
    return {2'b0, d};
  endfunction

  function automatic logic [CW-1:0] clamp(input logic signed [COORD_W-1:0] c);
    if (c < 0) return '0;
    if (c > COORD_W'(65536)) return CW'(65536);
    return c[CW-1:0];
  endfunction

  assign w_eff = eff_dim(wid_i);
  assign h_eff = eff_dim(hgt_i);
  assign u_c   = clamp(u_i);
  assign v_c   = clamp(v_i);

  // stage 1: scale by dimension - 1
  always_ff @(posedge clk) begin
    if (!rst_n) vld1_r <= 1'b0;
    else if (en) vld1_r <= vld_i;
    if (en) begin
      px_r <= PW'(u_c) * PW'(w_eff - DW'(1));
      py_r <= PW'(v_c) * PW'(h_eff - DW'(1));
      w1_r <= w_eff;
    end
  end

  // stage 2: neighbour indices
  logic [PW-FRAC_W-1:0] x0, y0, x1, y1;
  logic [FRAC_W-1:0]    s, t;
  assign x0 = px_r[PW-1:FRAC_W];
  assign y0 = py_r[PW-1:FRAC_W];
  assign s  = px_r[FRAC_W-1:0];
  assign t  = py_r[FRAC_W-1:0];
  assign x1 = x0 + ((s != '0) ? 1'b1 : 1'b0);
  assign y1 = y0 + ((t != '0) ? 1'b1 : 1'b0);

  logic [2*DW-1:0] r0, r1;
  assign r0 = (2*DW)'(y0) * (2*DW)'(w1_r);
  assign r1 = (2*DW)'(y1) * (2*DW)'(w1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) vld_o <= 1'b0;
    else if (en) vld_o <= vld1_r;
    if (en) begin
      a00_o <= AW'(r0 + (2*DW)'(x0));
      a10_o <= AW'(r0 + (2*DW)'(x1));
      a01_o <= AW'(r1 + (2*DW)'(x0));
      a11_o <= AW'(r1 + (2*DW)'(x1));
      s_o   <= s;
      t_o   <= t;
    end
  end
endmodule

### hdl/bts_blend.sv
// Blend stage: weights, per-channel products, sum and round. Three stages.
module bts_blend import bts_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  texel_t            tl_i,
  input  texel_t            tr_i,
  input  texel_t            bl_i,
  input  texel_t            br_i,
  input  logic [FRAC_W-1:0] s_i,
  input  logic [FRAC_W-1:0] t_i,
  output logic              vld_o,
  output logic [OUT_W-1:0]  r_o,
  output logic [OUT_W-1:0]  g_o,
  output logic [OUT_W-1:0]  b_o
);
  localparam int WW = 2*FRAC_W + 1;    // weight up to 2^32
  localparam int PRW = WW + CH_W;
  localparam int SW = PRW + 2;

  logic          vw_r, vp_r;
  logic [WW-1:0] w00_r, w10_r, w01_r, w11_r;
  texel_t        tl_r, tr_r, bl_r, br_r;
  logic [PRW-1:0] p_r [3][4];
  logic [FRAC_W:0] sc, tc;

  assign sc = (FRAC_W+1)'(65536) - {1'b0, s_i};
  assign tc = (FRAC_W+1)'(65536) - {1'b0, t_i};

  // stage 1: weights
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vw_r <= 1'b0; vp_r <= 1'b0; vld_o <= 1'b0;
    end else if (en) begin
      vw_r <= vld_i; vp_r <= vw_r; vld_o <= vp_r;
    end
    if (en) begin
      w00_r <= WW'(sc) * WW'(tc);
      w10_r <= WW'(s_i) * WW'(tc);
      w01_r <= WW'(sc) * WW'(t_i);
      w11_r <= WW'(s_i) * WW'(t_i);
      tl_r <= tl_i; tr_r <= tr_i; bl_r <= bl_i; br_r <= br_i;
    end
  end

  // stage 2: products (33x8)
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        p_r[c][0] <= PRW'(w00_r) * PRW'(tl_r[c*CH_W +: CH_W]);
        p_r[c][1] <= PRW'(w10_r) * PRW'(tr_r[c*CH_W +: CH_W]);
        p_r[c][2] <= PRW'(w01_r) * PRW'(bl_r[c*CH_W +: CH_W]);
        p_r[c][3] <= PRW'(w11_r) * PRW'(br_r[c*CH_W +: CH_W]);
      end
    end
  end

  // stage 3: sum and round to 8.8
  logic [SW-1:0] sum [3];
  always_comb begin
    for (int c = 0; c < 3; c++)
      sum[c] = SW'(p_r[c][0]) + SW'(p_r[c][1]) + SW'(p_r[c][2]) + SW'(p_r[c][3])
               + SW'(1 << 23);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_o <= sum[0][24 +: OUT_W];
      g_o <= sum[1][24 +: OUT_W];
      r_o <= sum[2][24 +: OUT_W];
    end
  end
endmodule

### hdl/bilinear_texture_sampler_unit.sv
// Bilinear texture sampler. Texels are written by linear index (op 0) and
// sampled at u,v (op 1, 65536 = 1.0, clamped to [0,1]); each sample returns
// red/green/blue in 8.8 fixed point. Fully pipelined: one item per cycle
// while the output is not held. A sample passes six register stages (2
// address, 1 memory read, 3 blend) before its output valid rises. The
// texture store is four copies of one memory so the four neighbours are read
// in the same cycle; a write updates all copies. A write travels the two
// address stages alongside the samples and lands in the memory at the read
// stage, so every sample sees exactly the writes that came before it. The
// whole pipe halts while the output is held. Registers may be written only
// while no sample is in flight.
module bilinear_texture_sampler_unit import bts_pkg::*; #(
  parameter int MAX_TEXELS = MAX_TEXELS_DEF,
  parameter int MAX_DIM    = MAX_DIM_DEF
) (
  input logic   clk,
  input logic   rst_n,
  bts_in_if.sink     in_ch,
  bts_out_if.source  out_ch,
  bts_cfg_if.sink    cfg_ch
);
  `include "bilinear_texture_sampler_unit_assert.svh"
  localparam int AW = $clog2(MAX_TEXELS);

  logic [DIM_W-1:0] tex_width_r, tex_height_r;
  logic en;
  logic sample;

  // pipeline advances unless a result is held at the output
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;
  assign cfg_ch.ready = 1'b1;
  assign sample = in_ch.valid && in_ch.ready && (in_ch.op == OP_SAMPLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_width_r  <= DIM_W'(256);
      tex_height_r <= DIM_W'(256);
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_TEX_WIDTH:  tex_width_r  <= cfg_ch.data;
        REG_TEX_HEIGHT: tex_height_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // texel write
  texel_t mem0 [MAX_TEXELS];
  texel_t mem1 [MAX_TEXELS];
  texel_t mem2 [MAX_TEXELS];
  texel_t mem3 [MAX_TEXELS];
  logic wr;
  logic [AW-1:0] wa;
  texel_t wd;
  assign wr = in_ch.valid && in_ch.ready && (in_ch.op == OP_WRITE) &&
              ({{(32-IDX_W){1'b0}}, in_ch.texel_index} < 32'(MAX_TEXELS));
  assign wa = AW'(in_ch.texel_index);
  assign wd = {in_ch.red_in, in_ch.green_in, in_ch.blue_in};

  // write delay line, matched to the two address stages
  logic          wr_d1_r, wr_d2_r;
  logic [AW-1:0] wa_d1_r, wa_d2_r;
  texel_t        wd_d1_r, wd_d2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_d1_r <= 1'b0;
      wr_d2_r <= 1'b0;
    end else if (en) begin
      wr_d1_r <= wr;
      wr_d2_r <= wr_d1_r;
    end
    if (en) begin
      wa_d1_r <= wa; wa_d2_r <= wa_d1_r;
      wd_d1_r <= wd; wd_d2_r <= wd_d1_r;
    end
  end

  logic          av;
  logic [AW-1:0] a00, a10, a01, a11;
  logic [FRAC_W-1:0] s, t;

  bts_addr #(.MAX_TEXELS(MAX_TEXELS), .MAX_DIM(MAX_DIM)) u_addr (
    .clk, .rst_n, .en, .vld_i(sample), .u_i(in_ch.u_coord), .v_i(in_ch.v_coord),
    .wid_i(tex_width_r), .hgt_i(tex_height_r), .vld_o(av),
    .a00_o(a00), .a10_o(a10), .a01_o(a01), .a11_o(a11), .s_o(s), .t_o(t)
  );

  // memory read stage
  texel_t tl_r, tr_r, bl_r, br_r;
  logic   mv_r;
  logic [FRAC_W-1:0] s_r, t_r;
  always_ff @(posedge clk) begin
    if (en && wr_d2_r) begin
      mem0[wa_d2_r] <= wd_d2_r; mem1[wa_d2_r] <= wd_d2_r;
      mem2[wa_d2_r] <= wd_d2_r; mem3[wa_d2_r] <= wd_d2_r;
    end
    if (en) begin
      tl_r <= mem0[a00]; tr_r <= mem1[a10]; bl_r <= mem2[a01]; br_r <= mem3[a11];
      s_r <= s; t_r <= t;
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) mv_r <= 1'b0;
    else if (en) mv_r <= av;
  end

  bts_blend u_blend (
    .clk, .rst_n, .en, .vld_i(mv_r), .tl_i(tl_r), .tr_i(tr_r), .bl_i(bl_r),
    .br_i(br_r), .s_i(s_r), .t_i(t_r), .vld_o(out_ch.valid),
    .r_o(out_ch.red_out), .g_o(out_ch.green_out), .b_o(out_ch.blue_out)
  );

  `BTS_ASSERT_NXT(a_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid)
  `BTS_ASSERT_IMP(a_write_no_result, clk, rst_n, wr_d2_r, !av)
  `BTS_ASSERT_IMP(a_red_range, clk, rst_n, out_ch.valid, out_ch.red_out <= 16'd65280)
endmodule

### dv/bilinear_texture_sampler_unit_test.sv
`timescale 1ns / 100ps

module bilinear_texture_sampler_unit_test;
  import bts_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int WATCHDOG_MAX = 3000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_SLACK  = 12;

  typedef struct {
    logic [OUT_W-1:0] chan [3];
  } rgb88_t;

  logic clk;
  logic rst_n;

  bts_in_if  in_if ();
  bts_out_if out_if ();
  bts_cfg_if cfg_if ();

  bilinear_texture_sampler_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // Shadow texture and register copies
  texel_t          texels [MAX_TEXELS_DEF];
  bit              texel_valid [MAX_TEXELS_DEF];
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;

  rgb88_t pending_rgb [$];
  int     fail_cnt;
  bit     steady;
  int     hold_reqs;
  int     hold_seen;
  int     hold_left;
  int     quiet_cycles;

  always #HALF_PERIOD clk = ~clk;

  function automatic int unsigned eff_dim(logic [DIM_W-1:0] d);
    if (d < 1) return 1;
    if (d > MAX_DIM_DEF) return MAX_DIM_DEF;
    return d;
  endfunction

  function automatic int unsigned clamp_coord(logic signed [COORD_W-1:0] c);
    int ci;
    ci = c;
    if (ci < 0) return 0;
    if (ci > 65536) return 65536;
    return ci;
  endfunction

  // Four neighbor indexes (tl, tr, bl, br) and the fractions s, t
  function automatic void find_taps(input logic signed [COORD_W-1:0] u,
                                    input logic signed [COORD_W-1:0] v,
                                    output int unsigned idx [4], output int unsigned s,
                                    output int unsigned t);
    int unsigned w, h, px, py, x0, y0, x1, y1;
    w  = eff_dim(width_reg);
    h  = eff_dim(height_reg);
    px = clamp_coord(u) * (w - 1);
    py = clamp_coord(v) * (h - 1);
    x0 = px >> 16;
    y0 = py >> 16;
    s  = px & 32'hFFFF;
    t  = py & 32'hFFFF;
    x1 = x0 + ((s != 0) ? 1 : 0);
    y1 = y0 + ((t != 0) ? 1 : 0);
    idx[0] = (x0 + y0 * w) % MAX_TEXELS_DEF;
    idx[1] = (x1 + y0 * w) % MAX_TEXELS_DEF;
    idx[2] = (x0 + y1 * w) % MAX_TEXELS_DEF;
    idx[3] = (x1 + y1 * w) % MAX_TEXELS_DEF;
  endfunction

  function automatic rgb88_t blend(logic signed [COORD_W-1:0] u, logic signed [COORD_W-1:0] v);
    int unsigned idx [4];
    int unsigned s, t;
    longint unsigned wt [4];
    longint unsigned sum;
    rgb88_t res;
    find_taps(u, v, idx, s, t);
    wt[0] = longint'(65536 - s) * longint'(65536 - t);
    wt[1] = longint'(s) * longint'(65536 - t);
    wt[2] = longint'(65536 - s) * longint'(t);
    wt[3] = longint'(s) * longint'(t);
    for (int ch = 0; ch < 3; ch++) begin
      sum = 0;
      for (int k = 0; k < 4; k++)
        sum += wt[k] * ((texels[idx[k]] >> (16 - 8 * ch)) & 8'hFF);
      res.chan[ch] = ((sum + (64'd1 << 23)) >> 24) & 16'hFFFF;
    end
    return res;
  endfunction

  // Drive one item and wait for its transfer; the model is updated on transfer
  task automatic send_item(logic op, logic [IDX_W-1:0] idx, texel_t rgb,
                           logic signed [COORD_W-1:0] u, logic signed [COORD_W-1:0] v);
    if (!steady && $urandom_range(99) < 8) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_if.op          <= op;
    in_if.texel_index <= idx;
    in_if.red_in      <= rgb[23:16];
    in_if.green_in    <= rgb[15:8];
    in_if.blue_in     <= rgb[7:0];
    in_if.u_coord     <= u;
    in_if.v_coord     <= v;
    in_if.valid       <= 1'b1;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (op == OP_WRITE) begin
      texels[idx]      = rgb;
      texel_valid[idx] = 1'b1;
    end else begin
      pending_rgb.push_back(blend(u, v));
    end
  endtask

  task automatic write_texel(logic [IDX_W-1:0] idx, texel_t rgb);
    send_item(OP_WRITE, idx, rgb, $urandom, $urandom);
  endtask

  // Sample; any neighbor never written gets a random texel first
  task automatic sample_at(logic signed [COORD_W-1:0] u, logic signed [COORD_W-1:0] v);
    int unsigned idx [4];
    int unsigned s, t;
    find_taps(u, v, idx, s, t);
    foreach (idx[k])
      if (!texel_valid[idx[k]]) write_texel(idx[k], $urandom);
    send_item(OP_SAMPLE, $urandom, $urandom, u, v);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_rgb.size() > 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    cfg_if.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    if (idx == REG_TEX_WIDTH) width_reg = data;
    else height_reg = data;
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_dims(logic [CFG_DAT_W-1:0] w, logic [CFG_DAT_W-1:0] h);
    wait_drained();
    write_reg(REG_TEX_WIDTH, w);
    write_reg(REG_TEX_HEIGHT, h);
  endtask

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(9))
      0: return $urandom;
      1: return -$signed({1'b0, 17'($urandom_range(1, 131072))});
      2: return 18'($urandom_range(65537, 131071));
      3: return '0;
      4: return 18'd65536;
      default: return 18'($urandom_range(0, 65536));
    endcase
  endfunction

  // Reset dimensions, coordinate extremes, color extremes
  task automatic test_coord_corners();
    logic signed [COORD_W-1:0] pts [8];
    pts = '{18'sh20000, 18'sh3FFFF, 18'sd0, 18'sd1, 18'sd32768, 18'sd65535, 18'sd65536,
            18'sh1FFFF};
    write_texel(0, 24'hFFFFFF);
    write_texel(1, 24'h000000);
    sample_at(18'sd0, 18'sd0);
    sample_at(18'sd32768, 18'sd0);
    set_dims(4, 3);
    foreach (pts[i]) sample_at(pts[i], pts[(i + 3) % 8]);
    sample_at(18'sh1FFFF, 18'sh20000);
    sample_at(18'sd65537, 18'sd65536);
  endtask

  // Zero and oversized dimensions, single row and single column
  task automatic test_degenerate_dims();
    set_dims(0, 0);
    sample_at(18'sd40000, 18'sd12345);
    set_dims(511, 300);
    sample_at(18'sd65536, 18'sd65536);
    sample_at(18'sd30001, 18'sd50002);
    set_dims(1, 256);
    sample_at(18'sd20000, 18'sd33333);
    set_dims(256, 1);
    sample_at(18'sd33333, 18'sd20000);
  endtask

  // Receiver holds off while the sender keeps offering
  task automatic test_output_stall();
    set_dims(8, 8);
    hold_reqs++;
    for (int i = 0; i < 60; i++) sample_at(rand_coord(), rand_coord());
  endtask

  // Sender pauses until every result is back, then resumes
  task automatic test_sender_pause();
    for (int i = 0; i < 20; i++) sample_at(rand_coord(), rand_coord());
    wait_drained();
    for (int i = 0; i < 20; i++) sample_at(rand_coord(), rand_coord());
  endtask

  task automatic test_random_mix();
    int unsigned w, h, span;
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 2) set_dims($urandom_range(0, 511), $urandom_range(0, 511));
      else set_dims($urandom_range(1, 16), $urandom_range(1, 16));
      steady = (phase == 3);
      w = eff_dim(width_reg);
      h = eff_dim(height_reg);
      span = w * h;
      for (int i = 0; i < 110; i++) begin
        if ($urandom_range(99) < 40) begin
          if ($urandom_range(9) < 7) write_texel($urandom_range(0, span - 1), $urandom);
          else write_texel($urandom, $urandom);
        end else begin
          sample_at(rand_coord(), rand_coord());
        end
      end
      steady = 1'b0;
    end
  endtask

  // Result receiver and checker
  always @(posedge clk) begin
    rgb88_t want;
    logic [OUT_W-1:0] got [3];
    if (rst_n && out_if.valid && out_if.ready) begin
      got = '{out_if.red_out, out_if.green_out, out_if.blue_out};
      if (pending_rgb.size() == 0) begin
        $display("%0t: unexpected result transfer r=%0d g=%0d b=%0d", $time,
                 got[0], got[1], got[2]);
        fail_cnt++;
      end else begin
        want = pending_rgb.pop_front();
        for (int ch = 0; ch < 3; ch++)
          if (got[ch] !== want.chan[ch]) begin
            $display("%0t: channel %0d expected %0d actual %0d", $time, ch,
                     want.chan[ch], got[ch]);
            fail_cnt++;
          end
      end
    end
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= steady || ($urandom_range(99) >= 8);
    end
  end

  // Watchdog on cycles with no transfer anywhere
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready) || !rst_n) begin
      quiet_cycles = 0;
    end else if (++quiet_cycles >= WATCHDOG_MAX) begin
      $display("bilinear_texture_sampler_unit verification failed");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.op = OP_WRITE;
    in_if.texel_index = '0;
    in_if.red_in = '0;
    in_if.green_in = '0;
    in_if.blue_in = '0;
    in_if.u_coord = '0;
    in_if.v_coord = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    width_reg = 9'd256;
    height_reg = 9'd256;
    fail_cnt = 0;
    steady = 1'b0;
    hold_reqs = 0;
    hold_seen = 0;
    hold_left = 0;
    quiet_cycles = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_coord_corners();
    test_degenerate_dims();
    test_output_stall();
    test_sender_pause();
    test_random_mix();
    wait_drained();
    if (fail_cnt == 0) begin
      $display("bilinear_texture_sampler_unit verification clean");
    end else begin
      $display("bilinear_texture_sampler_unit verification failed");
    end
    $finish;
  end
endmodule
